>>> hw/rtl/stbb_pkg.sv
// Shared constants and types for the swept triangle bounding box block.
`timescale 1ns / 1ps
`default_nettype none

package stbb_pkg;

    localparam int COORD_WIDTH  = 32;
    localparam int FRAC_BITS    = 16;
    localparam int LEAF_WIDTH   = 16;
    localparam int CORNER_WIDTH = 2;
    localparam int AXES         = 3;

    // Full product, the product after the fraction shift, and the sum with the corner.
    localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
    localparam int SHIFT_WIDTH = PROD_WIDTH - FRAC_BITS;
    localparam int SUM_WIDTH   = SHIFT_WIDTH + 1;

    // Both streams carry a leaf number and six coordinates, padded to whole bytes.
    localparam int PAYLOAD_BITS = LEAF_WIDTH + 2 * AXES * COORD_WIDTH;
    localparam int TDATA_WIDTH  = ((PAYLOAD_BITS + 7) / 8) * 8;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef enum logic [CORNER_WIDTH-1:0] {
        CORNER_START   = 2'd0,
        CORNER_EXTEND  = 2'd1,
        CORNER_CLOSE   = 2'd2,
        CORNER_IGNORED = 2'd3
    } corner_t;

    // One corner with its advanced point, handed from the advance pipe to the box logic.
    typedef struct packed {
        corner_t                 corner;
        logic [LEAF_WIDTH-1:0]   leaf;
        coord_t [AXES-1:0]       pos;
        coord_t [AXES-1:0]       adv;
    } swept_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/stbb_advance.sv
// Input register, per-axis multiply and saturating advance of one corner.
`timescale 1ns / 1ps
`default_nettype none

module stbb_advance (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire stbb_pkg::coord_t                 step_time,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // leaf_index, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    input  wire logic [stbb_pkg::TDATA_WIDTH-1:0] s_tdata,
    // corner
    input  wire logic [stbb_pkg::CORNER_WIDTH-1:0] s_tuser,
    output logic                                  adv_valid,
    input  wire logic                             adv_ready,
    output stbb_pkg::swept_item_t                 adv_item
);

    // Input stage.
    logic                                 in_valid_reg;
    stbb_pkg::corner_t                    in_corner_reg;
    logic [stbb_pkg::LEAF_WIDTH-1:0]      in_leaf_reg;
    stbb_pkg::coord_t                     in_pos_reg [stbb_pkg::AXES];
    stbb_pkg::coord_t                     in_vel_reg [stbb_pkg::AXES];

    // Product stage.
    logic                                 mul_valid_reg;
    stbb_pkg::corner_t                    mul_corner_reg;
    logic [stbb_pkg::LEAF_WIDTH-1:0]      mul_leaf_reg;
    stbb_pkg::coord_t                     mul_pos_reg [stbb_pkg::AXES];
    logic signed [stbb_pkg::SHIFT_WIDTH-1:0] mul_shift_reg  [stbb_pkg::AXES];
    logic signed [stbb_pkg::SHIFT_WIDTH-1:0] mul_shift_next [stbb_pkg::AXES];
    logic signed [stbb_pkg::PROD_WIDTH-1:0]  product        [stbb_pkg::AXES];

    // Advanced point stage.
    logic                                 adv_valid_reg;
    stbb_pkg::swept_item_t                adv_item_reg;
    stbb_pkg::swept_item_t                adv_item_next;
    logic signed [stbb_pkg::SUM_WIDTH-1:0] sum [stbb_pkg::AXES];

    stbb_pkg::corner_t s_corner;
    logic in_open;
    logic mul_open;
    logic adv_open;

    assign s_corner = stbb_pkg::corner_t'(s_tuser);

    assign adv_open = !adv_valid_reg || adv_ready;
    assign mul_open = !mul_valid_reg || adv_open;
    assign in_open  = !in_valid_reg || mul_open;
    assign s_tready = in_open;

    // Dropping the shifted-out fraction bits of the exact product floors toward minus infinity.
    always_comb begin
        for (int a = 0; a < stbb_pkg::AXES; a++) begin
            product[a] = stbb_pkg::PROD_WIDTH'(step_time)
                       * stbb_pkg::PROD_WIDTH'(in_vel_reg[a]);
            mul_shift_next[a] = product[a][stbb_pkg::PROD_WIDTH-1:stbb_pkg::FRAC_BITS];
        end
    end

    // The sum is in range when every bit above the coordinate sign bit matches it.
    always_comb begin
        adv_item_next.corner = mul_corner_reg;
        adv_item_next.leaf   = mul_leaf_reg;
        for (int a = 0; a < stbb_pkg::AXES; a++) begin
            adv_item_next.pos[a] = mul_pos_reg[a];
            sum[a] = {mul_shift_reg[a][stbb_pkg::SHIFT_WIDTH-1], mul_shift_reg[a]}
                   + {{(stbb_pkg::SUM_WIDTH - stbb_pkg::COORD_WIDTH)
                        {mul_pos_reg[a][stbb_pkg::COORD_WIDTH-1]}}, mul_pos_reg[a]};
            if ((&sum[a][stbb_pkg::SUM_WIDTH-1:stbb_pkg::COORD_WIDTH-1])
                    || !(|sum[a][stbb_pkg::SUM_WIDTH-1:stbb_pkg::COORD_WIDTH-1])) begin
                adv_item_next.adv[a] = sum[a][stbb_pkg::COORD_WIDTH-1:0];
            end else if (sum[a][stbb_pkg::SUM_WIDTH-1]) begin
                adv_item_next.adv[a] = {1'b1, {(stbb_pkg::COORD_WIDTH-1){1'b0}}};
            end else begin
                adv_item_next.adv[a] = {1'b0, {(stbb_pkg::COORD_WIDTH-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
            adv_valid_reg <= 1'b0;
        end else begin
            // An item with the ignored corner code is taken and then dropped.
            if (in_open) begin
                in_valid_reg <= s_tvalid && (s_corner != stbb_pkg::CORNER_IGNORED);
            end
            if (mul_open) begin
                mul_valid_reg <= in_valid_reg;
            end
            if (adv_open) begin
                adv_valid_reg <= mul_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_open && s_tvalid) begin
            in_corner_reg <= s_corner;
            in_leaf_reg   <= s_tdata[stbb_pkg::LEAF_WIDTH-1:0];
            for (int a = 0; a < stbb_pkg::AXES; a++) begin
                in_pos_reg[a] <= s_tdata[stbb_pkg::LEAF_WIDTH + a * stbb_pkg::COORD_WIDTH
                                         +: stbb_pkg::COORD_WIDTH];
                in_vel_reg[a] <= s_tdata[stbb_pkg::LEAF_WIDTH
                                         + (stbb_pkg::AXES + a) * stbb_pkg::COORD_WIDTH
                                         +: stbb_pkg::COORD_WIDTH];
            end
        end
        if (mul_open && in_valid_reg) begin
            mul_corner_reg <= in_corner_reg;
            mul_leaf_reg   <= in_leaf_reg;
            for (int a = 0; a < stbb_pkg::AXES; a++) begin
                mul_pos_reg[a]   <= in_pos_reg[a];
                mul_shift_reg[a] <= mul_shift_next[a];
            end
        end
        if (adv_open && mul_valid_reg) begin
            adv_item_reg <= adv_item_next;
        end
    end

    assign adv_valid = adv_valid_reg;
    assign adv_item  = adv_item_reg;

endmodule

`default_nettype wire

>>> hw/rtl/stbb_bound.sv
// Running per-axis box over corners and advanced points, and the result register.
`timescale 1ns / 1ps
`default_nettype none

module stbb_bound (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             adv_valid,
    output logic                                  adv_ready,
    input  wire stbb_pkg::swept_item_t            adv_item,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // box_leaf, min_x, min_y, min_z, max_x, max_y, max_z
    output logic [stbb_pkg::TDATA_WIDTH-1:0]      m_tdata
);

    stbb_pkg::coord_t low_reg   [stbb_pkg::AXES];
    stbb_pkg::coord_t high_reg  [stbb_pkg::AXES];
    stbb_pkg::coord_t low_next  [stbb_pkg::AXES];
    stbb_pkg::coord_t high_next [stbb_pkg::AXES];

    stbb_pkg::coord_t pos [stbb_pkg::AXES];
    stbb_pkg::coord_t adv [stbb_pkg::AXES];
    logic pos_below_adv [stbb_pkg::AXES];
    logic pos_below_low [stbb_pkg::AXES];
    logic adv_below_low [stbb_pkg::AXES];
    logic pos_above_high [stbb_pkg::AXES];
    logic adv_above_high [stbb_pkg::AXES];

    logic                            m_valid_reg;
    logic [stbb_pkg::LEAF_WIDTH-1:0] box_leaf_reg;
    stbb_pkg::coord_t                box_low_reg  [stbb_pkg::AXES];
    stbb_pkg::coord_t                box_high_reg [stbb_pkg::AXES];

    logic out_free;
    logic fire;
    logic restart;
    logic close;

    assign out_free  = !m_valid_reg || m_tready;
    assign close     = adv_item.corner == stbb_pkg::CORNER_CLOSE;
    assign restart   = adv_item.corner == stbb_pkg::CORNER_START;
    assign adv_ready = !close || out_free;
    assign fire      = adv_valid && adv_ready;

    // All compares run in parallel; selects take the 3-way min/max, 2-way on a start.
    always_comb begin
        for (int a = 0; a < stbb_pkg::AXES; a++) begin
            pos[a] = adv_item.pos[a];
            adv[a] = adv_item.adv[a];
            pos_below_adv[a]  = pos[a] < adv[a];
            pos_below_low[a]  = pos[a] < low_reg[a];
            adv_below_low[a]  = adv[a] < low_reg[a];
            pos_above_high[a] = pos[a] > high_reg[a];
            adv_above_high[a] = adv[a] > high_reg[a];
            if (restart) begin
                low_next[a]  = pos_below_adv[a] ? pos[a] : adv[a];
                high_next[a] = pos_below_adv[a] ? adv[a] : pos[a];
            end else if (pos_below_adv[a]) begin
                low_next[a]  = pos_below_low[a] ? pos[a] : low_reg[a];
                high_next[a] = adv_above_high[a] ? adv[a] : high_reg[a];
            end else begin
                low_next[a]  = adv_below_low[a] ? adv[a] : low_reg[a];
                high_next[a] = pos_above_high[a] ? pos[a] : high_reg[a];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire && close) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            for (int a = 0; a < stbb_pkg::AXES; a++) begin
                low_reg[a]  <= low_next[a];
                high_reg[a] <= high_next[a];
            end
        end
        if (fire && close) begin
            box_leaf_reg <= adv_item.leaf;
            for (int a = 0; a < stbb_pkg::AXES; a++) begin
                box_low_reg[a]  <= low_next[a];
                box_high_reg[a] <= high_next[a];
            end
        end
    end

    always_comb begin
        m_tdata = '0;
        m_tdata[stbb_pkg::LEAF_WIDTH-1:0] = box_leaf_reg;
        for (int a = 0; a < stbb_pkg::AXES; a++) begin
            m_tdata[stbb_pkg::LEAF_WIDTH + a * stbb_pkg::COORD_WIDTH
                    +: stbb_pkg::COORD_WIDTH] = box_low_reg[a];
            m_tdata[stbb_pkg::LEAF_WIDTH + (stbb_pkg::AXES + a) * stbb_pkg::COORD_WIDTH
                    +: stbb_pkg::COORD_WIDTH] = box_high_reg[a];
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

`default_nettype wire

>>> hw/rtl/swept_triangle_bounding_box.sv
// Top level of the swept triangle bounding box block.
//
//  Channel  | Direction | Contents
//  ---------+-----------+-------------------------------------------------------
//  cfg_*    | in        | step_time write, signed Q16.16, no read-back
//  s_*      | in        | one triangle corner: position and velocity, corner code
//  m_*      | out       | one box per completed triangle, tagged with its leaf
//
// One item is taken per cycle while the pipe is not stalled; a box appears on m_tvalid
// after its closing corner has passed the input, product, advanced point and result registers.
// The per-axis 32 x 32 multiply and the saturating add set the stage depth.
// A waiting result stalls the pipe only when a closing corner reaches the box logic;
// s_tready follows m_tready combinationally. Reset clears the valid flags and the
// time step; the running box holds no value until a starting corner arrives.
`timescale 1ns / 1ps
`default_nettype none

module swept_triangle_bounding_box (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    // step_time
    input  wire logic [stbb_pkg::COORD_WIDTH-1:0]  cfg_wdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // leaf_index, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    input  wire logic [stbb_pkg::TDATA_WIDTH-1:0]  s_tdata,
    // corner
    input  wire logic [stbb_pkg::CORNER_WIDTH-1:0] s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // box_leaf, min_x, min_y, min_z, max_x, max_y, max_z
    output logic [stbb_pkg::TDATA_WIDTH-1:0]       m_tdata
);

    stbb_pkg::coord_t      step_time_reg;
    logic                  adv_valid;
    logic                  adv_ready;
    stbb_pkg::swept_item_t adv_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_time_reg <= '0;
        end else if (cfg_we) begin
            step_time_reg <= cfg_wdata;
        end
    end

    stbb_advance u_advance (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_time (step_time_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .adv_valid (adv_valid),
        .adv_ready (adv_ready),
        .adv_item  (adv_item)
    );

    stbb_bound u_bound (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv_valid (adv_valid),
        .adv_ready (adv_ready),
        .adv_item  (adv_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // With the result side ready the whole pipe moves, so the input side is ready too.
    assert property (@(posedge aclk) disable iff (!aresetn) m_tready |-> s_tready)
        else $error("input side stalled while the result side is ready");

    // A new result can only come from an item that sat in the advanced point stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(adv_valid))
        else $error("result appeared without an item in the advance stage");

    // Only a closing corner produces a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (adv_valid && adv_ready && (adv_item.corner != stbb_pkg::CORNER_CLOSE)
            && m_tready) |=> !m_tvalid)
        else $error("result produced by a corner that does not close the box");

    // Clearing the reset leaves no result pending.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire
